FILE: hw/rtl/srr_pkg.sv
// types and constants shared by the serial reply receiver
`timescale 1ns / 1ps

package srr_pkg;

   localparam int WAIT_W    = 16;
   localparam int PAYLOAD_W = 7;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [WAIT_W-1:0]    WAIT_LIMIT_RESET   = 16'd16;
   localparam logic [PAYLOAD_W-1:0] PAYLOAD_BITS_RESET = 7'd32;

   localparam logic [CSR_IDX_W-1:0] CSR_WAIT_LIMIT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_BITS = 1'd1;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_WAIT = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      EV_START   = 2'd0,
      EV_BIT     = 2'd1,
      EV_TIMEOUT = 2'd2
   } event_type;

   typedef struct packed {
      logic              valid;
      event_type         event_res;
      logic              data_bit;
      logic [WAIT_W-1:0] busy_cycles;
      logic              is_last;
   } result_type;

endpackage

FILE: hw/rtl/srr_step.sv
// next-state and result logic for one sampled line bit
`timescale 1ns / 1ps

module srr_step #(
   parameter int MAX_PAYLOAD = 64,
   parameter int CRC_BITS    = 6,
   localparam int BL_W       = $clog2(MAX_PAYLOAD + CRC_BITS + 1)
) (
   input  logic                           line_bit,
   input  logic                           window_open,
   input  srr_pkg::phase_type             phase,
   input  logic [srr_pkg::WAIT_W-1:0]     busy_count,
   input  logic [BL_W-1:0]                bits_left,
   input  logic [srr_pkg::WAIT_W-1:0]     wait_limit,
   input  logic [srr_pkg::PAYLOAD_W-1:0]  payload_bits,
   output srr_pkg::phase_type             phase_next,
   output logic [srr_pkg::WAIT_W-1:0]     busy_next,
   output logic [BL_W-1:0]                bits_left_next,
   output srr_pkg::result_type            result
);

   srr_pkg::phase_type         ph;
   logic [srr_pkg::WAIT_W-1:0] bz;
   logic [srr_pkg::WAIT_W-1:0] bz_inc;
   logic [BL_W-1:0]            bl;
   logic [BL_W-1:0]            bl_dec;
   logic [BL_W-1:0]            n_bits;

   always_comb begin
      ph     = window_open ? srr_pkg::PH_WAIT : phase;
      bz     = window_open ? '0 : busy_count;
      bl     = window_open ? '0 : bits_left;
      bz_inc = bz + srr_pkg::WAIT_W'(1);
      bl_dec = (bl != '0) ? bl - BL_W'(1) : bl;
      // clamp oversized payload
      if (int'(payload_bits) > MAX_PAYLOAD) begin
         n_bits = BL_W'(MAX_PAYLOAD) + BL_W'(CRC_BITS);
      end else begin
         n_bits = BL_W'(payload_bits) + BL_W'(CRC_BITS);
      end

      phase_next            = ph;
      busy_next             = bz;
      bits_left_next        = bl;
      result.valid          = 1'b0;
      result.event_res      = srr_pkg::EV_START;
      result.data_bit       = 1'b0;
      result.busy_cycles    = '0;
      result.is_last        = 1'b0;

      unique case (ph)
         srr_pkg::PH_WAIT: begin
            if (bz >= wait_limit) begin
               phase_next       = srr_pkg::PH_IDLE;
               result.valid     = 1'b1;
               result.event_res = srr_pkg::EV_TIMEOUT;
               result.is_last   = 1'b1;
            end else if (line_bit) begin
               result.valid       = 1'b1;
               result.event_res   = srr_pkg::EV_START;
               result.busy_cycles = bz;
               if (payload_bits == '0) begin
                  phase_next     = srr_pkg::PH_IDLE;
                  bits_left_next = '0;
                  result.is_last = 1'b1;
               end else begin
                  phase_next     = srr_pkg::PH_DATA;
                  bits_left_next = n_bits;
               end
            end else begin
               busy_next = bz_inc;
               if (bz_inc >= wait_limit) begin
                  phase_next       = srr_pkg::PH_IDLE;
                  result.valid     = 1'b1;
                  result.event_res = srr_pkg::EV_TIMEOUT;
                  result.is_last   = 1'b1;
               end
            end
         end
         srr_pkg::PH_DATA: begin
            bits_left_next   = bl_dec;
            result.valid     = 1'b1;
            result.event_res = srr_pkg::EV_BIT;
            result.data_bit  = line_bit;
            result.is_last   = (bl_dec == '0);
            if (bl_dec == '0) begin
               phase_next = srr_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_next = srr_pkg::PH_IDLE;
         end
      endcase
   end

endmodule

FILE: hw/rtl/serial_reply_receiver.sv
// top level of the serial reply receiver: input stage, state and result register
//
//  channel  direction  tdata                          tuser            tlast
//  req_     in         [0] line_bit                   [0] window_open  -
//  rsp_     out        [0] data_bit, [16:1] busy      [1:0] event_res  is_last
//  csr_     in         wen, addr (0 wait_limit, 1 payload_bits), wdata
//
// one word per cycle sustained while rsp is not stalled; an rsp word comes from its req word
// through the input register, then single-pass step logic into the result register
// reset is synchronous: phase idle, counters zero, wait_limit 16, payload_bits 32
// a stalled rsp word holds the step stage; the input register still takes one word
`timescale 1ns / 1ps

module serial_reply_receiver #(
   parameter int MAX_PAYLOAD = 64,
   parameter int CRC_BITS    = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [0] line_bit
   input  logic                           req_tuser,   // [0] window_open
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // [0] data_bit, [16:1] busy_cycles
   output logic [1:0]                     rsp_tuser,   // [1:0] event_res
   output logic                           rsp_tlast,   // is_last
   input  logic                           csr_wen,
   input  logic [srr_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [srr_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int BL_W = $clog2(MAX_PAYLOAD + CRC_BITS + 1);

   logic [srr_pkg::WAIT_W-1:0]    wait_limit_ff;
   logic [srr_pkg::PAYLOAD_W-1:0] payload_bits_ff;

   logic in_valid_ff, in_valid_in;
   logic in_line_ff;
   logic in_open_ff;

   srr_pkg::phase_type         phase_ff, phase_in;
   logic [srr_pkg::WAIT_W-1:0] busy_count_ff, busy_count_in;
   logic [BL_W-1:0]            bits_left_ff, bits_left_in;

   srr_pkg::result_type        step_res;
   logic                       step_fire;

   logic                       rsp_valid_ff, rsp_valid_in;
   srr_pkg::event_type         rsp_event_ff;
   logic                       rsp_bit_ff;
   logic [srr_pkg::WAIT_W-1:0] rsp_busy_ff;
   logic                       rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wait_limit_ff   <= srr_pkg::WAIT_LIMIT_RESET;
         payload_bits_ff <= srr_pkg::PAYLOAD_BITS_RESET;
      end else if (csr_wen) begin
         unique case (csr_addr)
            srr_pkg::CSR_WAIT_LIMIT:   wait_limit_ff   <= csr_wdata;
            srr_pkg::CSR_PAYLOAD_BITS: payload_bits_ff <= csr_wdata[srr_pkg::PAYLOAD_W-1:0];
            default: ;
         endcase
      end
   end

   assign step_fire   = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || step_fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !step_fire);
   assign rsp_valid_in = (rsp_valid_ff && !rsp_tready) || (step_fire && step_res.valid);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_line_ff <= req_tdata[0];
         in_open_ff <= req_tuser;
      end
   end

   srr_step #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .CRC_BITS    (CRC_BITS)
   ) u_step (
      .line_bit       (in_line_ff),
      .window_open    (in_open_ff),
      .phase          (phase_ff),
      .busy_count     (busy_count_ff),
      .bits_left      (bits_left_ff),
      .wait_limit     (wait_limit_ff),
      .payload_bits   (payload_bits_ff),
      .phase_next     (phase_in),
      .busy_next      (busy_count_in),
      .bits_left_next (bits_left_in),
      .result         (step_res)
   );

   // receiver state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= srr_pkg::PH_IDLE;
         busy_count_ff <= '0;
         bits_left_ff  <= '0;
      end else if (step_fire) begin
         phase_ff      <= phase_in;
         busy_count_ff <= busy_count_in;
         bits_left_ff  <= bits_left_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire && step_res.valid) begin
         rsp_event_ff <= step_res.event_res;
         rsp_bit_ff   <= step_res.data_bit;
         rsp_busy_ff  <= step_res.busy_cycles;
         rsp_last_ff  <= step_res.is_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_busy_ff, rsp_bit_ff};
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a reply in progress always has bits left to send
   a_data_bits_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == srr_pkg::PH_DATA) |-> (bits_left_ff != '0))
      else $error("data phase with no bits left");

   // a timeout closes the reply and carries no busy count
   a_timeout_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_event_ff == srr_pkg::EV_TIMEOUT)) |->
      (rsp_last_ff && (rsp_busy_ff == '0)))
      else $error("timeout word not marked last or has busy count");

   // an opened window either keeps waiting or has produced a word
   a_open_progress: assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_open_ff) |=> ((phase_ff != srr_pkg::PH_IDLE) || rsp_valid_ff))
      else $error("window opened without state or result");

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the serial reply receiver with its own bit-level predictor
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_PAYLOAD    = 64;
   localparam int CRC_BITS       = 6;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ITEM_TARGET    = 1150;
   localparam int PRINT_LIMIT    = 100;

   typedef struct {
      logic line;
      logic win_open;
   } line_word_type;

   typedef struct {
      srr_pkg::event_type kind;
      logic               bit_val;
      logic [15:0]        busy;
      logic               last;
   } reply_word_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata = '0;
   logic                          req_tuser = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [23:0]                   rsp_tdata;
   logic [1:0]                    rsp_tuser;
   logic                          rsp_tlast;
   logic                          csr_wen = 1'b0;
   logic [srr_pkg::CSR_IDX_W-1:0] csr_addr = '0;
   logic [srr_pkg::CSR_W-1:0]     csr_wdata = '0;

   line_word_type  line_words[$];
   reply_word_type predicted_words[$];

   // predictor state and register copies
   srr_pkg::phase_type rx_phase = srr_pkg::PH_IDLE;
   logic [15:0]        rx_busy = '0;
   logic [6:0]         rx_left = '0;
   logic [15:0]        wait_limit_q = srr_pkg::WAIT_LIMIT_RESET;
   logic [6:0]         payload_q = srr_pkg::PAYLOAD_BITS_RESET;

   int  mismatches = 0;
   int  words_queued = 0;
   int  send_gap = 0;
   int  ready_gap = 0;
   int  hold_left = 0;
   int  stuck_cycles = 0;
   bit  hold_armed = 1'b0;
   bit  hold_taken = 1'b0;
   bit  no_idle = 1'b0;

   serial_reply_receiver #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .CRC_BITS   (CRC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),    // [0] line_bit
      .req_tuser (req_tuser),    // [0] window_open
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),    // [0] data_bit, [16:1] busy_cycles
      .rsp_tuser (rsp_tuser),    // [1:0] event_res
      .rsp_tlast (rsp_tlast),    // is_last
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int reply_length();
      int n;
      n = (payload_q > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_q;
      return (n == 0) ? 0 : n + CRC_BITS;
   endfunction

   function void receive_step(input logic line, input logic win_open);
      reply_word_type w;
      bit             has_word;
      int             n;
      has_word = 1'b0;
      w = '{srr_pkg::EV_START, 1'b0, 16'd0, 1'b0};
      if (win_open) begin
         rx_phase = srr_pkg::PH_WAIT;
         rx_busy  = '0;
         rx_left  = '0;
      end
      if (rx_phase == srr_pkg::PH_WAIT) begin
         if (rx_busy >= wait_limit_q) begin
            rx_phase = srr_pkg::PH_IDLE;
            w = '{srr_pkg::EV_TIMEOUT, 1'b0, 16'd0, 1'b1};
            has_word = 1'b1;
         end else if (line) begin
            n = (payload_q > MAX_PAYLOAD) ? MAX_PAYLOAD : payload_q;
            if (n == 0) begin
               rx_phase = srr_pkg::PH_IDLE;
               rx_left  = '0;
               w = '{srr_pkg::EV_START, 1'b0, rx_busy, 1'b1};
            end else begin
               rx_phase = srr_pkg::PH_DATA;
               rx_left  = 7'(n + CRC_BITS);
               w = '{srr_pkg::EV_START, 1'b0, rx_busy, 1'b0};
            end
            has_word = 1'b1;
         end else begin
            rx_busy = rx_busy + 16'd1;
            if (rx_busy >= wait_limit_q) begin
               rx_phase = srr_pkg::PH_IDLE;
               w = '{srr_pkg::EV_TIMEOUT, 1'b0, 16'd0, 1'b1};
               has_word = 1'b1;
            end
         end
      end else if (rx_phase == srr_pkg::PH_DATA) begin
         if (rx_left > 0) rx_left = rx_left - 7'd1;
         w = '{srr_pkg::EV_BIT, line, 16'd0, (rx_left == 0)};
         if (rx_left == 0) rx_phase = srr_pkg::PH_IDLE;
         has_word = 1'b1;
      end else begin
         rx_phase = srr_pkg::PH_IDLE;
      end
      if (has_word) predicted_words.push_back(w);
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) $display("mismatch: %s", msg);
      mismatches++;
   endtask

   // driver
   always @(posedge clock) begin
      line_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) receive_step(req_tdata[0], req_tuser);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (line_words.size() > 0) begin
               w = line_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, w.line};
               req_tuser  <= w.win_open;
               send_gap = no_idle ? 0 : idle_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      reply_word_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_gap = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word ev %0d bit %0b busy %0d last %0b",
                  rsp_tuser, rsp_tdata[0], rsp_tdata[16:1], rsp_tlast));
            end else begin
               want = predicted_words.pop_front();
               if (rsp_tuser !== want.kind || rsp_tdata[0] !== want.bit_val ||
                   rsp_tdata[16:1] !== want.busy || rsp_tlast !== want.last) begin
                  report_mismatch($sformatf(
                     "got ev %0d bit %0b busy %0d last %0b, want ev %0d bit %0b busy %0d last %0b",
                     rsp_tuser, rsp_tdata[0], rsp_tdata[16:1], rsp_tlast,
                     want.kind, want.bit_val, want.busy, want.last));
               end
            end
         end
         if (hold_armed && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (ready_gap > 0) begin
            ready_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            ready_gap = no_idle ? 0 : idle_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   task automatic push_word(input logic line, input logic win_open);
      line_words.push_back('{line, win_open});
      words_queued++;
   endtask

   task automatic push_idle(input int count);
      repeat (count) push_word(1'($urandom_range(0, 1)), 1'b0);
   endtask

   task automatic queue_window(input int zeros, input bit with_start, input int tail);
      bit first;
      first = 1'b1;
      repeat (zeros) begin
         push_word(1'b0, first);
         first = 1'b0;
      end
      if (with_start) begin
         push_word(1'b1, first);
         first = 1'b0;
      end
      repeat (tail) begin
         push_word(1'($urandom_range(0, 1)), first);
         first = 1'b0;
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (line_words.size() != 0 || req_tvalid || predicted_words.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limits(input logic [15:0] wait_lim, input logic [6:0] pay);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= srr_pkg::CSR_WAIT_LIMIT;
      csr_wdata <= wait_lim;
      @(posedge clock);
      csr_addr  <= srr_pkg::CSR_PAYLOAD_BITS;
      csr_wdata <= {9'($urandom_range(0, 511)), pay};
      @(posedge clock);
      csr_wen <= 1'b0;
      wait_limit_q = wait_lim;
      payload_q    = pay;
   endtask

   function automatic logic [15:0] pick_wait();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 16'd0;
      if (r < 16) return 16'd1;
      if (r < 24) return 16'hFFFF;
      if (r < 34) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(2, 24));
   endfunction

   function automatic logic [6:0] pick_payload();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 7'd0;
      if (r < 15) return 7'd64;
      if (r < 20) return 7'd127;
      if (r < 25) return 7'($urandom_range(65, 126));
      if (r < 30) return 7'($urandom_range(0, 127));
      return 7'($urandom_range(1, 8));
   endfunction

   initial begin
      int phase_no;
      int target;
      int pick;
      int room;
      int zeros;
      int len;
      phase_no = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset values, then a new window while a reply is running
      push_word(1'b1, 1'b1);
      push_word(1'b1, 1'b0);
      push_word(1'b0, 1'b1);
      push_word(1'b1, 1'b0);
      push_word(1'b0, 1'b0);
      wait_idle();
      // zero wait limit times out at once
      set_limits(16'd0, 7'd0);
      push_word(1'b1, 1'b1);
      push_word(1'b0, 1'b0);
      wait_idle();
      // acknowledge only, then an idle clock
      set_limits(16'hFFFF, 7'd0);
      push_word(1'b0, 1'b1);
      push_word(1'b0, 1'b0);
      push_word(1'b1, 1'b0);
      push_word(1'b1, 1'b0);
      wait_idle();
      // timeout on the limit, then a reply with a one-bit payload
      set_limits(16'd2, 7'd1);
      push_word(1'b0, 1'b1);
      push_word(1'b0, 1'b0);
      push_word(1'b1, 1'b1);
      push_word(1'b1, 1'b0);
      push_word(1'b0, 1'b0);
      push_word(1'b1, 1'b0);
      push_word(1'b0, 1'b0);
      push_word(1'b1, 1'b0);
      push_word(1'b0, 1'b0);
      push_word(1'b1, 1'b0);
      wait_idle();
      // limit lowered below the count while waiting
      set_limits(16'd5, 7'd127);
      push_word(1'b0, 1'b1);
      push_word(1'b0, 1'b0);
      wait_idle();
      set_limits(16'd1, 7'd64);
      push_word(1'b1, 1'b0);
      wait_idle();

      while (words_queued < ITEM_TARGET) begin
         set_limits(pick_wait(), pick_payload());
         @(negedge clock);
         no_idle = (phase_no % 4 == 1);
         if (phase_no == 2) hold_armed = 1'b1;
         target = words_queued + $urandom_range(30, 90);
         while (words_queued < target) begin
            pick = $urandom_range(0, 99);
            len  = reply_length();
            room = (wait_limit_q == 0) ? 0 : wait_limit_q - 1;
            if (room > 40) room = 40;
            zeros = ($urandom_range(0, 9) == 0) ? room : $urandom_range(0, (room < 6) ? room : 6);
            if (pick < 70) begin
               queue_window(zeros, 1'b1, len);
            end else if (pick < 80 && wait_limit_q <= 40) begin
               queue_window((wait_limit_q == 0) ? 1 : wait_limit_q + $urandom_range(0, 2),
                            1'b0, 0);
            end else if (pick < 90) begin
               queue_window(zeros, 1'b1, $urandom_range(0, len));
            end else begin
               repeat ($urandom_range(1, 5))
                  push_word(1'($urandom_range(0, 1)), ($urandom_range(0, 4) == 0));
            end
            push_idle($urandom_range(0, 2));
         end
         wait_idle();
         phase_no++;
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (predicted_words.size() != 0)
         report_mismatch($sformatf("%0d words never arrived", predicted_words.size()));
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

FILE: serial_reply_receiver.f
hw/rtl/srr_pkg.sv
hw/rtl/srr_step.sv
hw/rtl/serial_reply_receiver.sv
tb/sv/testbench.sv
